>>> sv/two_class_priority_queue_assert.svh
// Assertion macros for the two-class priority queue checker.
// No dependencies.
`ifndef TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TCPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define TCPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

>>> sv/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, codes and state types.
// No dependencies.
`default_nettype none
package tcpq_pkg;
  localparam int DepthDef = 16;
  localparam int IdBitsDef = 16;
  localparam int AgeBitsDef = 7;
  localparam int ThrBits = 7;
  localparam int CntBits = 5;
  localparam logic [ThrBits-1:0] ThrReset = 7'd60;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SERVE = 2'd1,
    ACT_WITHDRAW = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_PCHK,
    S_NRD,
    S_NCHK,
    S_DEC,
    S_SRD,
    S_SCHK,
    S_LINK,
    S_FIX,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> sv/tcpq_slot_mem.sv
// Slot memory of the queue: id, age and next link per slot, registered read.
// Depends on tcpq_pkg.
`default_nettype none
module tcpq_slot_mem #(
  parameter int DEPTH = tcpq_pkg::DepthDef,
  parameter int ID_BITS = tcpq_pkg::IdBitsDef,
  parameter int AGE_BITS = tcpq_pkg::AgeBitsDef,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [ID_BITS-1:0]  rd_id,
  output logic      [AGE_BITS-1:0] rd_age,
  output logic      [AW-1:0]       rd_next,
  input  wire logic                wr_full,
  input  wire logic                wr_link,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [ID_BITS-1:0]  wr_id,
  input  wire logic [AGE_BITS-1:0] wr_age,
  input  wire logic [AW-1:0]       wr_next
);
  import tcpq_pkg::*;
  logic [ID_BITS-1:0] id_mem [DEPTH];
  logic [AGE_BITS-1:0] age_mem [DEPTH];
  logic [AW-1:0] next_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_full) begin
      id_mem[wr_addr] <= wr_id;
      age_mem[wr_addr] <= wr_age;
    end
    if (wr_full || wr_link) begin
      next_mem[wr_addr] <= wr_next;
    end
    rd_id <= id_mem[rd_addr];
    rd_age <= age_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> sv/two_class_priority_queue.sv
// Two-class priority queue: top level with sequencer, list pointers and slot memory.
// Depends on tcpq_pkg and tcpq_slot_mem.
//
// Usage: one item in on the in_ stream (action, id, age in tdata) gives one
// item out on the out_ stream (status, served_id, found_age, entry_count).
// Entries whose age is at or above the threshold written through cfg_ go to
// the priority list, which serves before the normal list; each list is FIFO.
// For insert, withdraw and query, the id search walks both linked lists in the
// slot memory, one read per slot; the slot memory read is registered.
// A result sits in an output register; the next item can be taken in the cycle
// after the result is taken, so a stalled receiver holds the block.
// Reset (synchronous rst_n low) empties both lists and sets the threshold to
// 60; no clearing pass is needed.
`default_nettype none
module two_class_priority_queue #(
  parameter int DEPTH = tcpq_pkg::DepthDef,
  parameter int ID_BITS = tcpq_pkg::IdBitsDef,
  parameter int AGE_BITS = tcpq_pkg::AgeBitsDef,
  parameter int IN_W = ((2 + ID_BITS + AGE_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((2 + ID_BITS + AGE_BITS + tcpq_pkg::CntBits + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // action, id, age
  input  wire logic [IN_W-1:0]              in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // status, served_id, found_age, entry_count
  output logic      [OUT_W-1:0]             out_tdata,
  input  wire logic                         cfg_we,
  input  wire logic [tcpq_pkg::ThrBits-1:0] cfg_wdata
);
  import tcpq_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PAD = OUT_W - (2 + ID_BITS + AGE_BITS + CntBits);

  state_t state_r, state_nxt;
  logic [ThrBits-1:0] thr_r;
  logic [1:0] act_r, act_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic [DEPTH-1:0] used_r, used_nxt;
  logic [AW-1:0] ph_r, ph_nxt, pt_r, pt_nxt, nh_r, nh_nxt, nt_r, nt_nxt;
  logic [CW-1:0] pc_r, pc_nxt, nc_r, nc_nxt;
  logic [AW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, slot_r, slot_nxt;
  logic pv_r, pv_nxt, inp_r, inp_nxt, found_r, found_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [AW-1:0] fnext_r, fnext_nxt;
  logic [AGE_BITS-1:0] fage_r, fage_nxt;
  logic [1:0] st_r, st_nxt;
  logic [ID_BITS-1:0] sid_r, sid_nxt;
  logic [AGE_BITS-1:0] oage_r, oage_nxt;
  logic ov_r, ov_nxt;
  logic [AW-1:0] rd_addr;
  logic [ID_BITS-1:0] rd_id;
  logic [AGE_BITS-1:0] rd_age;
  logic [AW-1:0] rd_next;
  logic wr_full, wr_link;
  logic [AW-1:0] wr_addr, wr_next, free_slot;
  logic free_any;

  tcpq_slot_mem #(.DEPTH(DEPTH), .ID_BITS(ID_BITS), .AGE_BITS(AGE_BITS), .AW(AW)) u_mem (
    .clk, .rd_addr, .rd_id, .rd_age, .rd_next, .wr_full, .wr_link, .wr_addr,
    .wr_id(key_r), .wr_age(age_r), .wr_next
  );

  always_comb begin
    free_any = 1'b0;
    free_slot = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_any = 1'b1;
        free_slot = AW'(k);
      end
    end
  end

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {{PAD{1'b0}}, CntBits'(pc_r) + CntBits'(nc_r), oage_r, sid_r, st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_r <= ThrReset;
      used_r <= '0;
      ph_r <= '0; pt_r <= '0; nh_r <= '0; nt_r <= '0;
      pc_r <= '0; nc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      used_r <= used_nxt;
      ph_r <= ph_nxt; pt_r <= pt_nxt; nh_r <= nh_nxt; nt_r <= nt_nxt;
      pc_r <= pc_nxt; nc_r <= nc_nxt;
      ov_r <= ov_nxt;
    end
    act_r <= act_nxt; key_r <= key_nxt; age_r <= age_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; slot_r <= slot_nxt;
    pv_r <= pv_nxt; inp_r <= inp_nxt; found_r <= found_nxt; i_r <= i_nxt;
    fnext_r <= fnext_nxt; fage_r <= fage_nxt;
    st_r <= st_nxt; sid_r <= sid_nxt; oage_r <= oage_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; key_nxt = key_r; age_nxt = age_r;
    used_nxt = used_r;
    ph_nxt = ph_r; pt_nxt = pt_r; nh_nxt = nh_r; nt_nxt = nt_r;
    pc_nxt = pc_r; nc_nxt = nc_r;
    cur_nxt = cur_r; prev_nxt = prev_r; slot_nxt = slot_r;
    pv_nxt = pv_r; inp_nxt = inp_r; found_nxt = found_r; i_nxt = i_r;
    fnext_nxt = fnext_r; fage_nxt = fage_r;
    st_nxt = st_r; sid_nxt = sid_r; oage_nxt = oage_r;
    ov_nxt = ov_r && !out_tready;
    rd_addr = cur_r;
    wr_full = 1'b0; wr_link = 1'b0; wr_addr = slot_r; wr_next = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          act_nxt = in_tdata[1:0];
          key_nxt = in_tdata[2 +: ID_BITS];
          age_nxt = in_tdata[2 + ID_BITS +: AGE_BITS];
          st_nxt = ST_DONE; sid_nxt = '0; oage_nxt = '0;
          found_nxt = 1'b0; pv_nxt = 1'b0; i_nxt = '0;
          if (in_tdata[1:0] == ACT_SERVE) begin
            state_nxt = S_SRD;
          end else begin
            cur_nxt = ph_r;
            state_nxt = S_PRD;
          end
        end
      end
      S_PRD, S_NRD: begin
        if (i_r == ((state_r == S_PRD) ? pc_r : nc_r)) begin
          if (state_r == S_PRD) begin
            cur_nxt = nh_r; i_nxt = '0; pv_nxt = 1'b0; state_nxt = S_NRD;
          end else begin
            state_nxt = S_DEC;
          end
        end else begin
          state_nxt = (state_r == S_PRD) ? S_PCHK : S_NCHK;
        end
      end
      S_PCHK, S_NCHK: begin
        if (rd_id == key_r) begin
          found_nxt = 1'b1; inp_nxt = (state_r == S_PCHK);
          slot_nxt = cur_r; fnext_nxt = rd_next; fage_nxt = rd_age;
          state_nxt = S_DEC;
        end else begin
          prev_nxt = cur_r; pv_nxt = 1'b1; cur_nxt = rd_next;
          i_nxt = i_r + 1'b1;
          state_nxt = (state_r == S_PCHK) ? S_PRD : S_NRD;
        end
      end
      S_SRD: begin
        if (pc_r != '0) begin
          rd_addr = ph_r; slot_nxt = ph_r; inp_nxt = 1'b1; state_nxt = S_SCHK;
        end else if (nc_r != '0) begin
          rd_addr = nh_r; slot_nxt = nh_r; inp_nxt = 1'b0; state_nxt = S_SCHK;
        end else begin
          st_nxt = ST_MISS; state_nxt = S_OUT;
        end
      end
      S_SCHK: begin
        sid_nxt = rd_id; fnext_nxt = rd_next; pv_nxt = 1'b0;
        state_nxt = S_FIX;
      end
      S_DEC: begin
        state_nxt = S_OUT;
        priority case (act_r)
          ACT_INSERT: begin
            if (found_r) begin
              st_nxt = ST_DUP;
            end else if (!free_any) begin
              st_nxt = ST_FULL;
            end else begin
              slot_nxt = free_slot;
              wr_full = 1'b1; wr_addr = free_slot; wr_next = '0;
              used_nxt[free_slot] = 1'b1;
              state_nxt = S_LINK;
            end
          end
          ACT_QUERY: begin
            if (found_r) oage_nxt = fage_r;
            else st_nxt = ST_MISS;
          end
          default: begin
            if (found_r) state_nxt = S_FIX;
            else st_nxt = ST_MISS;
          end
        endcase
      end
      S_LINK: begin
        state_nxt = S_OUT;
        if (age_r >= AGE_BITS'(thr_r) && (AGE_BITS >= ThrBits || age_r >= thr_r)) begin
          if (pc_r == '0) ph_nxt = slot_r;
          else begin wr_link = 1'b1; wr_addr = pt_r; wr_next = slot_r; end
          pt_nxt = slot_r; pc_nxt = pc_r + 1'b1;
        end else begin
          if (nc_r == '0) nh_nxt = slot_r;
          else begin wr_link = 1'b1; wr_addr = nt_r; wr_next = slot_r; end
          nt_nxt = slot_r; nc_nxt = nc_r + 1'b1;
        end
      end
      S_FIX: begin
        state_nxt = S_OUT;
        used_nxt[slot_r] = 1'b0;
        if (pv_r) begin
          wr_link = 1'b1; wr_addr = prev_r; wr_next = fnext_r;
        end
        if (inp_r) begin
          if (!pv_r) ph_nxt = fnext_r;
          if (pt_r == slot_r) pt_nxt = pv_r ? prev_r : '0;
          pc_nxt = pc_r - 1'b1;
          if (pc_r == CW'(1)) begin ph_nxt = '0; pt_nxt = '0; end
        end else begin
          if (!pv_r) nh_nxt = fnext_r;
          if (nt_r == slot_r) nt_nxt = pv_r ? prev_r : '0;
          nc_nxt = nc_r - 1'b1;
          if (nc_r == CW'(1)) begin nh_nxt = '0; nt_nxt = '0; end
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/tcpq_checker.sv
// Port checker for the two-class priority queue, bound to the top level.
// Depends on two_class_priority_queue_assert.svh.
`default_nettype none
`include "two_class_priority_queue_assert.svh"
module tcpq_checker #(
  parameter int OUT_W = 32
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  `TCPQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TCPQ_ASSERT_IMP(a_no_take_while_out, clk, rst_n, out_tvalid, !in_tready)
  `TCPQ_ASSERT_NXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !out_tvalid && !in_tready)
endmodule

bind two_class_priority_queue tcpq_checker #(.OUT_W(OUT_W)) u_tcpq_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
